// ===== hdl/sector_cache_lru_controller_assert.svh =====
// Assertion macros shared by the sector cache checker.
// No dependencies; included by scl_checker.sv.
`ifndef SECTOR_CACHE_LRU_CONTROLLER_ASSERT_SVH
`define SECTOR_CACHE_LRU_CONTROLLER_ASSERT_SVH
// Same-cycle implication, quiet during reset.
`define SCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sector cache check failed");
// Next-cycle implication, quiet during reset.
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sector cache check failed");
`endif

// ===== hdl/scl_pkg.sv =====
// Shared types and codes for the sector cache tag controller.
// No dependencies; used by scl_front, scl_cmd_fifo, scl_back, the top level and scl_checker.
`timescale 1ns / 1ps

package scl_pkg;

    localparam int SECTOR_W = 32;
    localparam int ENTRY_W  = 6;

    // Request operation codes
    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_CLAIM   = 3'd2;
    localparam logic [2:0] OP_FINISH  = 3'd3;
    localparam logic [2:0] OP_EVDONE  = 3'd4;

    // Response status codes
    localparam logic [3:0] STS_HIT        = 4'd0;
    localparam logic [3:0] STS_MISS_CLEAN = 4'd1;
    localparam logic [3:0] STS_MISS_DIRTY = 4'd2;
    localparam logic [3:0] STS_BUSY       = 4'd3;
    localparam logic [3:0] STS_EVICTING   = 4'd4;
    localparam logic [3:0] STS_NONE_FREE  = 4'd5;
    localparam logic [3:0] STS_DONE       = 4'd6;
    localparam logic [3:0] STS_CLAIMED    = 4'd7;
    localparam logic [3:0] STS_NONE_DIRTY = 4'd8;
    localparam logic [3:0] STS_ERROR      = 4'd9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0]          operation;
        logic [SECTOR_W-1:0] sector;
        logic                is_meta;
        logic [ENTRY_W-1:0]  entry;
        logic                dirty;
    } req_t;

    typedef struct packed {
        logic [3:0]          status;
        logic [ENTRY_W-1:0]  entry_index;
        logic [SECTOR_W-1:0] writeback_sector;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_ACQUIRE,
        CMD_RELEASE,
        CMD_CLAIM,
        CMD_FINISH,
        CMD_EVDONE,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SECTOR_W-1:0] sector;
        logic                is_meta;
        logic [ENTRY_W-1:0]  entry;
        logic                dirty;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hdl/scl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/scl_front.sv =====
// Front end: accepts request beats and classifies them into commands.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_front #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                  req_valid,
    output logic                  req_ready,
    input  scl_pkg::req_t         req,
    input  scl_pkg::queue_status_t q_status,
    output logic                  push,
    output scl_pkg::cmd_t         push_cmd
);

    localparam logic [8:0] ENT_LIMIT = 9'(ENTRIES);

    logic [SECTOR_BITS-1:0] sec_masked;
    logic                   bad_sector;
    logic                   entry_ok;

    // Take a beat whenever the queue has room
    assign req_ready = !q_status.full;
    assign push      = req_valid && req_ready;

    assign sec_masked = SECTOR_BITS'(req.sector);
    assign bad_sector = &sec_masked;
    assign entry_ok   = ({3'b000, req.entry} < ENT_LIMIT);

    // Classify the request; flag malformed ones here
    always_comb
    begin
        push_cmd.sector  = req.sector;
        push_cmd.is_meta = req.is_meta;
        push_cmd.entry   = req.entry;
        push_cmd.dirty   = req.dirty;
        unique case (req.operation)
            scl_pkg::OP_ACQUIRE:
                push_cmd.kind = bad_sector ? scl_pkg::CMD_ERROR : scl_pkg::CMD_ACQUIRE;
            scl_pkg::OP_CLAIM:
                push_cmd.kind = scl_pkg::CMD_CLAIM;
            scl_pkg::OP_RELEASE:
                push_cmd.kind = entry_ok ? scl_pkg::CMD_RELEASE : scl_pkg::CMD_ERROR;
            scl_pkg::OP_FINISH:
                push_cmd.kind = entry_ok ? scl_pkg::CMD_FINISH : scl_pkg::CMD_ERROR;
            scl_pkg::OP_EVDONE:
                push_cmd.kind = entry_ok ? scl_pkg::CMD_EVDONE : scl_pkg::CMD_ERROR;
            default:
                push_cmd.kind = scl_pkg::CMD_ERROR;
        endcase
    end

endmodule

// ===== hdl/scl_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_cmd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  scl_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output scl_pkg::cmd_t          pop_cmd,
    output scl_pkg::queue_status_t q_status
);

    localparam int CW = $clog2(scl_pkg::QUEUE_DEPTH + 1);

    scl_pkg::cmd_t                 mem_reg [scl_pkg::QUEUE_DEPTH];
    logic [scl_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [scl_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]                 count_reg;

    assign q_status.full  = (count_reg == CW'(scl_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = mem_reg[rd_ptr_reg];

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/scl_lru_pick.sv =====
// Registered minimum tree: finds the candidate entry with the lowest
// recency rank in three stages of eight-way compares. No dependencies.
`timescale 1ns / 1ps

module scl_lru_pick #(
    parameter int ENTRIES = 64
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [ENTRIES-1:0]                        mask,
    input  logic [ENTRIES-1:0][$clog2(ENTRIES)-1:0]   rank,
    output logic                                      done,
    output logic [$clog2(ENTRIES)-1:0]                pick_idx,
    output logic [$clog2(ENTRIES)-1:0]                pick_rank
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int GROUP = 8;
    localparam int N1    = (ENTRIES + GROUP - 1) / GROUP;
    localparam int N2    = (N1 + GROUP - 1) / GROUP;

    logic [N1-1:0]         l1_v_c;
    logic [N1-1:0][IW-1:0] l1_r_c;
    logic [N1-1:0][IW-1:0] l1_x_c;
    logic [N1-1:0]         l1_v_reg;
    logic [N1-1:0][IW-1:0] l1_r_reg;
    logic [N1-1:0][IW-1:0] l1_x_reg;

    logic [N2-1:0]         l2_v_c;
    logic [N2-1:0][IW-1:0] l2_r_c;
    logic [N2-1:0][IW-1:0] l2_x_c;
    logic [N2-1:0]         l2_v_reg;
    logic [N2-1:0][IW-1:0] l2_r_reg;
    logic [N2-1:0][IW-1:0] l2_x_reg;

    logic                  l3_v_c;
    logic [IW-1:0]         l3_r_c;
    logic [IW-1:0]         l3_x_c;
    logic [IW-1:0]         l3_r_reg;
    logic [IW-1:0]         l3_x_reg;

    logic                  s1_reg;
    logic                  s2_reg;
    logic                  s3_reg;

    // Stage one: oldest candidate within each group of eight entries
    always_comb
    begin
        for (int g = 0; g < N1; g++)
        begin
            l1_v_c[g] = 1'b0;
            l1_r_c[g] = '0;
            l1_x_c[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < ENTRIES)
                begin
                    if (mask[g * GROUP + k] &&
                        (!l1_v_c[g] || rank[g * GROUP + k] < l1_r_c[g]))
                    begin
                        l1_v_c[g] = 1'b1;
                        l1_r_c[g] = rank[g * GROUP + k];
                        l1_x_c[g] = IW'(g * GROUP + k);
                    end
                end
            end
        end
    end

    // Stage two: oldest across groups of eight stage-one winners
    always_comb
    begin
        for (int h = 0; h < N2; h++)
        begin
            l2_v_c[h] = 1'b0;
            l2_r_c[h] = '0;
            l2_x_c[h] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (h * GROUP + k < N1)
                begin
                    if (l1_v_reg[h * GROUP + k] &&
                        (!l2_v_c[h] || l1_r_reg[h * GROUP + k] < l2_r_c[h]))
                    begin
                        l2_v_c[h] = 1'b1;
                        l2_r_c[h] = l1_r_reg[h * GROUP + k];
                        l2_x_c[h] = l1_x_reg[h * GROUP + k];
                    end
                end
            end
        end
    end

    // Stage three: final pick over the few stage-two winners
    always_comb
    begin
        l3_v_c = 1'b0;
        l3_r_c = '0;
        l3_x_c = '0;
        for (int h = 0; h < N2; h++)
        begin
            if (l2_v_reg[h] && (!l3_v_c || l2_r_reg[h] < l3_r_c))
            begin
                l3_v_c = 1'b1;
                l3_r_c = l2_r_reg[h];
                l3_x_c = l2_x_reg[h];
            end
        end
    end

    // Tree payload registers
    always_ff @(posedge clk)
    begin
        l1_v_reg <= l1_v_c;
        l1_r_reg <= l1_r_c;
        l1_x_reg <= l1_x_c;
        l2_v_reg <= l2_v_c;
        l2_r_reg <= l2_r_c;
        l2_x_reg <= l2_x_c;
        l3_r_reg <= l3_r_c;
        l3_x_reg <= l3_x_c;
    end

    // Track the search through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            s3_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= start;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    assign done      = s3_reg;
    assign pick_idx  = l3_x_reg;
    assign pick_rank = l3_r_reg;

endmodule

// ===== hdl/scl_back.sv =====
// Back end: tag cells, flags, recency ranks and the command sequencer.
// Depends on scl_pkg, scl_lru_pick and scl_ram.
`timescale 1ns / 1ps

module scl_back #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scl_pkg::queue_status_t q_status,
    input  scl_pkg::cmd_t          q_cmd,
    output logic                   pop,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output scl_pkg::rsp_t          rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_RANK = IW'(ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SEARCH = 5'b01000,
        S_APPLY  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Current command
    scl_pkg::cmd_kind_t     cmd_kind_reg;
    logic [SECTOR_BITS-1:0] cmd_sec_reg;
    logic                   cmd_meta_reg;
    logic [IW-1:0]          cmd_ent_reg;
    logic                   cmd_dirty_reg;

    // Cache state
    logic [SECTOR_BITS-1:0]       tag_reg   [ENTRIES];
    logic [SECTOR_BITS-1:0]       evict_reg [ENTRIES];
    logic [ENTRIES-1:0]           busy_reg;
    logic [ENTRIES-1:0]           mod_reg;
    logic [ENTRIES-1:0]           meta_flag_reg;
    logic [ENTRIES-1:0]           evicting_reg;
    logic [ENTRIES-1:0][IW-1:0]   rank_reg;

    logic [ENTRIES-1:0] tag_hit_reg;
    logic [ENTRIES-1:0] ev_hit_reg;
    logic [IW-1:0]      tag_idx;
    logic [IW-1:0]      ev_idx;
    logic [ENTRIES-1:0] free_data;
    logic [ENTRIES-1:0] free_meta;
    logic [ENTRIES-1:0] dirty_cand;
    logic [ENTRIES-1:0] ent_onehot;

    // Search unit and tag mirror
    logic               start;
    logic [ENTRIES-1:0] mask;
    logic               pick_done;
    logic [IW-1:0]      pick_idx;
    logic [IW-1:0]      pick_rank;
    logic [IW-1:0]      pick_idx_reg;
    logic [IW-1:0]      pick_rank_reg;
    logic               ram_re;
    logic [SECTOR_BITS-1:0] ram_rdata;

    // Result and update controls
    logic          out_free;
    logic          finish;
    logic          commit;
    scl_pkg::rsp_t res;
    logic [IW-1:0] u_idx;
    logic          u_busy_set;
    logic          u_busy_clr;
    logic          u_tag_wr;
    logic          u_ev_set;
    logic          u_ev_clr;
    logic          u_mod_set;
    logic          u_mod_clr;
    logic          u_rank_move;

    logic          rsp_valid_reg;
    scl_pkg::rsp_t rsp_reg;

    assign free_data  = ~busy_reg & ~meta_flag_reg;
    assign free_meta  = ~busy_reg & meta_flag_reg;
    assign dirty_cand = mod_reg & ~evicting_reg;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign commit     = finish && out_free;

    always_comb
    begin
        ent_onehot              = '0;
        ent_onehot[cmd_ent_reg] = 1'b1;
    end

    // Encode the (unique) tag and eviction matches
    always_comb
    begin
        tag_idx = '0;
        ev_idx  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tag_hit_reg[i])
            begin
                tag_idx = tag_idx | IW'(i);
            end
            if (ev_hit_reg[i])
            begin
                ev_idx = ev_idx | IW'(i);
            end
        end
    end

    scl_lru_pick #(
        .ENTRIES(ENTRIES)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mask      (mask),
        .rank      (rank_reg),
        .done      (pick_done),
        .pick_idx  (pick_idx),
        .pick_rank (pick_rank)
    );

    // Mirror of the tags for reading one entry's sector
    scl_ram #(
        .WIDTH(SECTOR_BITS),
        .DEPTH(ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (commit && u_tag_wr),
        .waddr (u_idx),
        .wdata (cmd_sec_reg),
        .re    (ram_re),
        .raddr (pick_idx),
        .rdata (ram_rdata)
    );

    // Sequencer: decide, search, apply
    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        start       = 1'b0;
        mask        = '0;
        ram_re      = 1'b0;
        finish      = 1'b0;
        res         = '0;
        u_idx       = cmd_ent_reg;
        u_busy_set  = 1'b0;
        u_busy_clr  = 1'b0;
        u_tag_wr    = 1'b0;
        u_ev_set    = 1'b0;
        u_ev_clr    = 1'b0;
        u_mod_set   = 1'b0;
        u_mod_clr   = 1'b0;
        u_rank_move = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                unique case (cmd_kind_reg)
                    scl_pkg::CMD_ACQUIRE:
                    begin
                        if (|tag_hit_reg)
                        begin
                            finish            = 1'b1;
                            u_idx             = tag_idx;
                            res.entry_index   = scl_pkg::ENTRY_W'(tag_idx);
                            if (busy_reg[tag_idx])
                            begin
                                res.status = scl_pkg::STS_BUSY;
                            end
                            else
                            begin
                                res.status = scl_pkg::STS_HIT;
                                u_busy_set = 1'b1;
                            end
                        end
                        else if (|ev_hit_reg)
                        begin
                            finish          = 1'b1;
                            res.status      = scl_pkg::STS_EVICTING;
                            res.entry_index = scl_pkg::ENTRY_W'(ev_idx);
                        end
                        else if (|free_data)
                        begin
                            start = 1'b1;
                            mask  = free_data;
                        end
                        else if (|free_meta)
                        begin
                            start = 1'b1;
                            mask  = free_meta;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            res.status = scl_pkg::STS_NONE_FREE;
                        end
                    end
                    scl_pkg::CMD_RELEASE, scl_pkg::CMD_FINISH:
                    begin
                        if (busy_reg[cmd_ent_reg] && !evicting_reg[cmd_ent_reg])
                        begin
                            // look up the entry's rank through the tree
                            start = 1'b1;
                            mask  = ent_onehot;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            res.status = scl_pkg::STS_ERROR;
                        end
                    end
                    scl_pkg::CMD_CLAIM:
                    begin
                        if (|dirty_cand)
                        begin
                            start = 1'b1;
                            mask  = dirty_cand;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            res.status = scl_pkg::STS_NONE_DIRTY;
                        end
                    end
                    scl_pkg::CMD_EVDONE:
                    begin
                        finish = 1'b1;
                        if (evicting_reg[cmd_ent_reg])
                        begin
                            res.status      = scl_pkg::STS_DONE;
                            res.entry_index = scl_pkg::ENTRY_W'(cmd_ent_reg);
                            u_ev_clr        = 1'b1;
                            u_mod_clr       = 1'b1;
                        end
                        else
                        begin
                            res.status = scl_pkg::STS_ERROR;
                        end
                    end
                    default:
                    begin
                        finish     = 1'b1;
                        res.status = scl_pkg::STS_ERROR;
                    end
                endcase
                if (start)
                begin
                    state_next = S_SEARCH;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (pick_done)
                begin
                    ram_re     = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                finish          = 1'b1;
                u_idx           = pick_idx_reg;
                res.entry_index = scl_pkg::ENTRY_W'(pick_idx_reg);
                unique case (cmd_kind_reg)
                    scl_pkg::CMD_ACQUIRE:
                    begin
                        u_busy_set = 1'b1;
                        u_tag_wr   = 1'b1;
                        if (mod_reg[pick_idx_reg])
                        begin
                            u_ev_set             = 1'b1;
                            res.status           = scl_pkg::STS_MISS_DIRTY;
                            res.writeback_sector = scl_pkg::SECTOR_W'(ram_rdata);
                        end
                        else
                        begin
                            res.status = scl_pkg::STS_MISS_CLEAN;
                        end
                    end
                    scl_pkg::CMD_CLAIM:
                    begin
                        if (busy_reg[pick_idx_reg])
                        begin
                            res.status = scl_pkg::STS_BUSY;
                        end
                        else
                        begin
                            u_busy_set           = 1'b1;
                            res.status           = scl_pkg::STS_CLAIMED;
                            res.writeback_sector = scl_pkg::SECTOR_W'(ram_rdata);
                        end
                    end
                    scl_pkg::CMD_RELEASE:
                    begin
                        u_busy_clr  = 1'b1;
                        u_mod_set   = cmd_dirty_reg;
                        u_rank_move = 1'b1;
                        res.status  = scl_pkg::STS_DONE;
                    end
                    scl_pkg::CMD_FINISH:
                    begin
                        u_busy_clr  = 1'b1;
                        u_mod_clr   = 1'b1;
                        u_rank_move = 1'b1;
                        res.status  = scl_pkg::STS_DONE;
                    end
                    default:
                    begin
                        res             = '0;
                        res.status      = scl_pkg::STS_ERROR;
                    end
                endcase
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Load the popped command and the parallel match vectors
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_kind_reg  <= q_cmd.kind;
            cmd_sec_reg   <= SECTOR_BITS'(q_cmd.sector);
            cmd_meta_reg  <= q_cmd.is_meta;
            cmd_ent_reg   <= IW'(q_cmd.entry);
            cmd_dirty_reg <= q_cmd.dirty;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            tag_hit_reg[i] <= (tag_reg[i] == cmd_sec_reg);
            ev_hit_reg[i]  <= (evict_reg[i] == cmd_sec_reg);
        end
        if (state_reg == S_SEARCH && pick_done)
        begin
            pick_idx_reg  <= pick_idx;
            pick_rank_reg <= pick_rank;
        end
    end

    // Update tags, flags and recency ranks on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_reg[i]   <= '1;
                evict_reg[i] <= '1;
                rank_reg[i]  <= IW'(i);
            end
            busy_reg      <= '0;
            mod_reg       <= '0;
            meta_flag_reg <= '0;
            evicting_reg  <= '0;
        end
        else if (commit)
        begin
            if (u_busy_set)
            begin
                busy_reg[u_idx] <= 1'b1;
            end
            if (u_busy_clr)
            begin
                busy_reg[u_idx] <= 1'b0;
            end
            if (u_tag_wr)
            begin
                tag_reg[u_idx]       <= cmd_sec_reg;
                meta_flag_reg[u_idx] <= cmd_meta_reg;
            end
            if (u_ev_set)
            begin
                evict_reg[u_idx]    <= ram_rdata;
                evicting_reg[u_idx] <= 1'b1;
            end
            if (u_ev_clr)
            begin
                evict_reg[u_idx]    <= '1;
                evicting_reg[u_idx] <= 1'b0;
            end
            if (u_mod_set)
            begin
                mod_reg[u_idx] <= 1'b1;
            end
            if (u_mod_clr)
            begin
                mod_reg[u_idx] <= 1'b0;
            end
            if (u_rank_move)
            begin
                // move to most recent; close the gap behind it
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IW'(i) == u_idx)
                    begin
                        rank_reg[i] <= LAST_RANK;
                    end
                    else if (rank_reg[i] > pick_rank_reg)
                    begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
            end
        end
    end

    // Output register: hold until the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/sector_cache_lru_controller.sv =====
// Sector cache LRU tag controller: top level.
// Depends on scl_pkg, scl_front, scl_cmd_fifo and scl_back.
//
// Usage:
//   Requests arrive on req (valid/ready); each request beat yields exactly
//   one response beat on rsp (valid/ready), in request order.
//   A two-deep command queue sits between the front end and the back end,
//   so requests are still taken while a response waits to be drained.
//   Hits, busy hits, evicting, none-free, none-dirty, errors and
//   eviction-done are answered from the decide state; misses, claims,
//   releases and writeback finishes first run the three-stage recency
//   search tree and a read of the tag mirror RAM, then the apply state.
//   The back end works on one command at a time and pops the next one
//   only from its idle state, once the current response is registered.
//   Reset: all tags invalid, nothing busy, modified or evicting, and the
//   recency order is entry 0 oldest to the last entry newest.
//   A stalled receiver holds the response register; the back end waits
//   with its result, then the queue fills and req_ready drops.
`timescale 1ns / 1ps

module sector_cache_lru_controller #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  scl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output scl_pkg::rsp_t rsp
);

    logic                   push;
    scl_pkg::cmd_t          push_cmd;
    logic                   pop;
    scl_pkg::cmd_t          pop_cmd;
    scl_pkg::queue_status_t q_status;

    scl_front #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    scl_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    scl_back #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/scl_checker.sv =====
// Port-level checks for the sector cache tag controller, bound to the top.
// Depends on scl_pkg and sector_cache_lru_controller_assert.svh.
`timescale 1ns / 1ps
`include "sector_cache_lru_controller_assert.svh"

module scl_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input scl_pkg::rsp_t rsp
);

    // A stalled response beat holds
    `SCL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // Status stays within the defined codes
    `SCL_ASSERT_IMPLY(a_status_range, clk, rst_n, rsp_valid, rsp.status <= scl_pkg::STS_ERROR)

    // No entry is reported when nothing was found
    `SCL_ASSERT_IMPLY(a_idx_zero, clk, rst_n, rsp_valid && (rsp.status == scl_pkg::STS_NONE_FREE || rsp.status == scl_pkg::STS_NONE_DIRTY || rsp.status == scl_pkg::STS_ERROR), rsp.entry_index == '0)

    // Only dirty misses and claims carry a writeback sector
    `SCL_ASSERT_IMPLY(a_wb_zero, clk, rst_n, rsp_valid && rsp.status != scl_pkg::STS_MISS_DIRTY && rsp.status != scl_pkg::STS_CLAIMED, rsp.writeback_sector == '0)

endmodule

bind sector_cache_lru_controller scl_checker u_checker (.*);
